// ----- sv/mbr_pkg.sv -----
// shared constants and tempering function for the bounded mt19937 generator
`timescale 1ns / 1ps
package mbr_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] INIT_SEED = 32'd5489;
  localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- sv/mbr_ram.sv -----
// generic single-write dual-read ram with registered read data
`timescale 1ns / 1ps
module mbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/mt19937_bounded_random.sv -----
// top level: mt19937 generator with result reduced modulo bound plus one
`timescale 1ns / 1ps
// Each beat on the slave side carries an upper bound; one beat on the master side
// returns the next MT19937 output, tempered, modulo bound+1 (a bound of all ones
// returns the tempered word as is). The 624-word state sits in one RAM. After reset
// and after every seed write the state is filled from the seed, each word through a
// multiply state and then an add state, and no request is taken meanwhile. The
// remainder comes from the restoring divider that produces one remainder bit per
// cycle; one request in 624 (the first after seeding, then every 624th) first
// regenerates the whole state in place. One request is in flight at a time; a new
// one is taken while a finished result waits.
module mt19937_bounded_random
  import mbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,       // seed_value
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [WORD_W-1:0] s_axis_tdata,    // upper_bound
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata     // random_value
);

  localparam logic [3:0] ST_FL_START = 4'd0;
  localparam logic [3:0] ST_FL_MUL   = 4'd1;
  localparam logic [3:0] ST_FL_ADD   = 4'd2;
  localparam logic [3:0] ST_IDLE     = 4'd3;
  localparam logic [3:0] ST_RG_INIT  = 4'd4;
  localparam logic [3:0] ST_RG_FIRST = 4'd5;
  localparam logic [3:0] ST_RG_RD    = 4'd6;
  localparam logic [3:0] ST_RG_WR    = 4'd7;
  localparam logic [3:0] ST_RD       = 4'd8;
  localparam logic [3:0] ST_TEMPER   = 4'd9;
  localparam logic [3:0] ST_DIV      = 4'd10;
  localparam logic [3:0] ST_OUT      = 4'd11;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [IDX_W-1:0] OFS_IDX  = IDX_W'(SHIFT_OFFSET);

  logic [3:0]        state;
  logic [WORD_W-1:0] seed;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  k;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] divisor;
  logic              full_range;
  logic [WORD_W-1:0] dividend;
  logic [WORD_W-1:0] rem;
  logic [4:0]        bit_cnt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  logic [IDX_W-1:0]  k_plus1;
  logic [IDX_W-1:0]  k_plus_ofs;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] twist_v;
  logic [WORD_W-1:0] fill_v;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_sub;

  mbr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign k_plus1    = (k == LAST_IDX) ? '0 : k + IDX_W'(1);
  assign k_plus_ofs = (k >= WRAP_IDX) ? k - WRAP_IDX : k + OFS_IDX;

  assign twist_y = {cur[WORD_W-1], rdata_a[WORD_W-2:0]};
  assign twist_v = rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);
  assign fill_v  = prod + {{(WORD_W-IDX_W){1'b0}}, k};

  assign rem_sh  = {rem, dividend[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = twist_v;
    raddr_a   = k_plus1;
    raddr_b   = k_plus_ofs;
    case (state)
      ST_FL_START: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed;
      end
      ST_FL_ADD: begin
        ram_we    = 1'b1;
        ram_wdata = fill_v;
      end
      ST_RG_WR: begin
        ram_we = 1'b1;
      end
      ST_RG_INIT: begin
        raddr_a = '0;
      end
      ST_RD: begin
        raddr_a = pos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FL_START;
      seed          <= INIT_SEED;
      pos           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && (cfg_we || state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        seed  <= cfg_wdata;
        pos   <= '0;
        state <= ST_FL_START;
      end else begin
        case (state)
          ST_FL_START: begin
            prev  <= seed;
            k     <= IDX_W'(1);
            state <= ST_FL_MUL;
          end
          ST_FL_MUL: begin
            prod  <= INIT_MULT * (prev ^ (prev >> 30));
            state <= ST_FL_ADD;
          end
          ST_FL_ADD: begin
            prev <= fill_v;
            if (k == LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + IDX_W'(1);
              state <= ST_FL_MUL;
            end
          end
          ST_IDLE: begin
            if (s_axis_tvalid) begin
              full_range <= &s_axis_tdata;
              divisor    <= s_axis_tdata + WORD_W'(1);
              k          <= '0;
              state      <= (pos == '0) ? ST_RG_INIT : ST_RD;
            end
          end
          ST_RG_INIT: begin
            state <= ST_RG_FIRST;
          end
          ST_RG_FIRST: begin
            cur   <= rdata_a;
            state <= ST_RG_WR;
          end
          ST_RG_RD: begin
            state <= ST_RG_WR;
          end
          ST_RG_WR: begin
            cur <= rdata_a;
            if (k == LAST_IDX) begin
              state <= ST_RD;
            end else begin
              k     <= k + IDX_W'(1);
              state <= ST_RG_RD;
            end
          end
          ST_RD: begin
            pos   <= (pos == LAST_IDX) ? '0 : pos + IDX_W'(1);
            state <= ST_TEMPER;
          end
          ST_TEMPER: begin
            if (full_range) begin
              rem   <= temper(rdata_a);
              state <= ST_OUT;
            end else begin
              dividend <= temper(rdata_a);
              rem      <= '0;
              bit_cnt  <= 5'd31;
              state    <= ST_DIV;
            end
          end
          ST_DIV: begin
            rem      <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0] : rem_sub[WORD_W-1:0];
            dividend <= dividend << 1;
            bit_cnt  <= bit_cnt - 5'd1;
            if (bit_cnt == 5'd0) begin
              state <= ST_OUT;
            end
          end
          ST_OUT: begin
            if (!m_axis_tvalid || m_axis_tready) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= rem;
              state         <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule
